// ----- rtl/core/ldq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ldq_pkg
// Shared types and constants for the linked deque manager: pool size, link
// encoding, operation codes, sequencer states and inter-module structs.
// ----------------------------------------------------------------------------
package ldq_pkg;

    localparam int NODE_COUNT = 256;
    localparam int IDX_W      = 8;          // node_index field width
    localparam int LINK_W     = IDX_W + 1;  // link code, one above the pool is nil
    localparam int COUNT_W    = 9;          // entry_total field width
    localparam int IN_W       = 16;         // input word, padded to bytes
    localparam int OUT_W      = 24;         // result word, padded to bytes

    localparam logic [LINK_W-1:0] NIL_CODE = LINK_W'(NODE_COUNT);

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_UNLINK     = 3'd6,
        OP_CLEAR      = 3'd7
    } ldq_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ldq_state_t;

    // one read port shared by both link tables, one write port on each
    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              nx_we;
        logic [IDX_W-1:0]  nx_addr;
        logic [LINK_W-1:0] nx_data;
        logic              pv_we;
        logic [IDX_W-1:0]  pv_addr;
        logic [LINK_W-1:0] pv_data;
    } ldq_mem_req_t;

    typedef struct packed {
        logic               misuse;
        logic [COUNT_W-1:0] entry_total;
        logic               is_empty;
        logic               found;
        logic [IDX_W-1:0]   result_node;
    } ldq_result_t;

    function automatic logic link_valid(input logic [LINK_W-1:0] link);
        return link < NIL_CODE;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ldq_link_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ldq_link_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ldq_link_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 9,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- rtl/core/ldq_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ldq_seq
// Two-step sequencer: the accept step reads the target's links (or writes a
// new node's own links), the exec step patches the neighbor links and updates
// head, tail, count and membership.
// ----------------------------------------------------------------------------
module ldq_seq import ldq_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire ldq_op_t           in_op,
    input  wire logic [IDX_W-1:0]  in_node,
    output logic                   in_ready,
    input  wire logic              out_free,
    output logic                   res_valid,
    output ldq_result_t            res,
    output ldq_mem_req_t           mem_req,
    input  wire logic [LINK_W-1:0] nx_rd,
    input  wire logic [LINK_W-1:0] pv_rd
);

    ldq_state_t                state_reg, state_next;
    ldq_op_t                   op_reg, op_next;
    logic [IDX_W-1:0]          tgt_reg, tgt_next;
    logic                      act_reg, act_next;
    logic [LINK_W-1:0]         head_reg, head_next;
    logic [LINK_W-1:0]         tail_reg, tail_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic [NODE_COUNT-1:0]     member_reg, member_next;

    logic                      node_ok;
    logic                      node_mem;
    logic [LINK_W-1:0]         tgt_link;

    assign node_ok  = {1'b0, in_node} < NIL_CODE;
    assign node_mem = member_reg[in_node];
    assign tgt_link = {1'b0, tgt_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            op_reg     <= OP_CLEAR;
            tgt_reg    <= '0;
            act_reg    <= 1'b0;
            head_reg   <= NIL_CODE;
            tail_reg   <= NIL_CODE;
            count_reg  <= '0;
            member_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            tgt_reg    <= tgt_next;
            act_reg    <= act_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            member_reg <= member_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        tgt_next    = tgt_reg;
        act_next    = act_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        member_next = member_reg;
        mem_req     = '0;
        res         = '0;
        res_valid   = 1'b0;
        in_ready    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                    op_next    = in_op;
                    tgt_next   = in_node;
                    act_next   = 1'b0;
                    case (in_op)
                        OP_PUSH_FRONT:
                        begin
                            act_next = node_ok && !node_mem;
                            if (node_ok && !node_mem)
                            begin
                                mem_req.nx_we   = 1'b1;
                                mem_req.nx_addr = in_node;
                                mem_req.nx_data = head_reg;
                                mem_req.pv_we   = 1'b1;
                                mem_req.pv_addr = in_node;
                                mem_req.pv_data = NIL_CODE;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            act_next = node_ok && !node_mem;
                            if (node_ok && !node_mem)
                            begin
                                mem_req.nx_we   = 1'b1;
                                mem_req.nx_addr = in_node;
                                mem_req.nx_data = NIL_CODE;
                                mem_req.pv_we   = 1'b1;
                                mem_req.pv_addr = in_node;
                                mem_req.pv_data = tail_reg;
                            end
                        end
                        OP_POP_FRONT, OP_PEEK_FRONT:
                        begin
                            tgt_next = head_reg[IDX_W-1:0];
                            act_next = link_valid(head_reg);
                        end
                        OP_POP_BACK, OP_PEEK_BACK:
                        begin
                            tgt_next = tail_reg[IDX_W-1:0];
                            act_next = link_valid(tail_reg);
                        end
                        OP_UNLINK:
                        begin
                            act_next = node_ok && node_mem;
                        end
                        default:
                        begin
                            act_next = 1'b1;
                        end
                    endcase
                    // target links come back for the exec step
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = tgt_next;
                end
            end

            ST_EXEC:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                    case (op_reg)
                        OP_PUSH_FRONT:
                        begin
                            if (act_reg)
                            begin
                                if (link_valid(head_reg))
                                begin
                                    mem_req.pv_we   = 1'b1;
                                    mem_req.pv_addr = head_reg[IDX_W-1:0];
                                    mem_req.pv_data = tgt_link;
                                end
                                head_next = tgt_link;
                                if (!link_valid(tail_reg))
                                begin
                                    tail_next = tgt_link;
                                end
                                member_next[tgt_reg] = 1'b1;
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (act_reg)
                            begin
                                if (link_valid(tail_reg))
                                begin
                                    mem_req.nx_we   = 1'b1;
                                    mem_req.nx_addr = tail_reg[IDX_W-1:0];
                                    mem_req.nx_data = tgt_link;
                                end
                                tail_next = tgt_link;
                                if (!link_valid(head_reg))
                                begin
                                    head_next = tgt_link;
                                end
                                member_next[tgt_reg] = 1'b1;
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK, OP_UNLINK:
                        begin
                            if (act_reg)
                            begin
                                if (tgt_link == head_reg)
                                begin
                                    head_next = nx_rd;
                                    if (link_valid(nx_rd))
                                    begin
                                        mem_req.pv_we   = 1'b1;
                                        mem_req.pv_addr = nx_rd[IDX_W-1:0];
                                        mem_req.pv_data = NIL_CODE;
                                    end
                                    else
                                    begin
                                        tail_next = NIL_CODE;
                                    end
                                end
                                else if (tgt_link == tail_reg)
                                begin
                                    tail_next = pv_rd;
                                    if (link_valid(pv_rd))
                                    begin
                                        mem_req.nx_we   = 1'b1;
                                        mem_req.nx_addr = pv_rd[IDX_W-1:0];
                                        mem_req.nx_data = NIL_CODE;
                                    end
                                    else
                                    begin
                                        head_next = NIL_CODE;
                                    end
                                end
                                else
                                begin
                                    // middle node: both neighbors patched in the same cycle
                                    if (link_valid(pv_rd))
                                    begin
                                        mem_req.nx_we   = 1'b1;
                                        mem_req.nx_addr = pv_rd[IDX_W-1:0];
                                        mem_req.nx_data = nx_rd;
                                    end
                                    if (link_valid(nx_rd))
                                    begin
                                        mem_req.pv_we   = 1'b1;
                                        mem_req.pv_addr = nx_rd[IDX_W-1:0];
                                        mem_req.pv_data = pv_rd;
                                    end
                                end
                                member_next[tgt_reg] = 1'b0;
                                if (count_reg != '0)
                                begin
                                    count_next = count_reg - COUNT_W'(1);
                                end
                            end
                        end
                        OP_PEEK_FRONT, OP_PEEK_BACK:
                        begin
                        end
                        default:
                        begin
                            head_next   = NIL_CODE;
                            tail_next   = NIL_CODE;
                            count_next  = '0;
                            member_next = '0;
                        end
                    endcase

                    res.found       = act_reg && (op_reg inside {OP_POP_FRONT, OP_POP_BACK,
                                                                 OP_PEEK_FRONT, OP_PEEK_BACK});
                    res.result_node = res.found ? tgt_reg : '0;
                    res.misuse      = !act_reg && (op_reg inside {OP_PUSH_FRONT, OP_PUSH_BACK,
                                                                  OP_UNLINK});
                    res.is_empty    = !link_valid(head_next);
                    res.entry_total = count_next;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/linked_deque_manager.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// linked_deque_manager
// Doubly linked deque over a fixed pool of node indices, next and previous
// links held in two synchronous RAMs, one result word per command word.
// ----------------------------------------------------------------------------
//  channel   direction  tdata fields (lsb first)
//  s_axis    in         operation[2:0], node_index[10:3], zero pad [15:11]
//  m_axis    out        result_node[7:0], found[8], is_empty[9],
//                       entry_total[18:10], misuse[19], zero pad [23:20]
//
//  every command runs an accept step, which issues the link RAM read (or
//  writes a pushed node's own links), then an exec step, which writes the
//  neighbor link back and loads the output register; the exec step waits
//  while the output register is full
//  the next command is taken while a finished result waits in the output reg
//  reset clears head, tail, count and all membership flops at once; link
//  RAMs need no clearing pass
// ----------------------------------------------------------------------------
module linked_deque_manager import ldq_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,   // operation, node_index
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic      [OUT_W-1:0] m_axis_tdata    // result_node, found, is_empty,
                                                  // entry_total, misuse
);

    ldq_mem_req_t       mem_req;
    ldq_result_t        res;
    logic               res_valid;
    logic               out_free;
    logic [LINK_W-1:0]  nx_rd;
    logic [LINK_W-1:0]  pv_rd;

    logic               m_tvalid_reg, m_tvalid_next;
    ldq_result_t        m_res_reg;

    assign out_free = !m_tvalid_reg || m_axis_tready;

    ldq_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_op     (ldq_op_t'(s_axis_tdata[2:0])),
        .in_node   (s_axis_tdata[IDX_W+2:3]),
        .in_ready  (s_axis_tready),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_req   (mem_req),
        .nx_rd     (nx_rd),
        .pv_rd     (pv_rd)
    );

    ldq_link_ram #(
        .DEPTH (NODE_COUNT),
        .WIDTH (LINK_W)
    ) u_next_ram (
        .clk     (clk),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (nx_rd),
        .wr_en   (mem_req.nx_we),
        .wr_addr (mem_req.nx_addr),
        .wr_data (mem_req.nx_data)
    );

    ldq_link_ram #(
        .DEPTH (NODE_COUNT),
        .WIDTH (LINK_W)
    ) u_prev_ram (
        .clk     (clk),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (pv_rd),
        .wr_en   (mem_req.pv_we),
        .wr_addr (mem_req.pv_addr),
        .wr_data (mem_req.pv_data)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            m_res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {(OUT_W - $bits(ldq_result_t))'(0), m_res_reg};

endmodule
`default_nettype wire

// ----- tb/linked_deque_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// linked_deque_checker
// Watches both stream channels of the linked deque manager. It keeps its own
// copy of the deque (links, membership, head, tail, count) and works out the
// result word for every accepted command word. Each accepted result word is
// compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module linked_deque_checker import ldq_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    input  wire logic             s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,     // operation, node_index
    input  wire logic             m_axis_tvalid,
    input  wire logic             m_axis_tready,
    input  wire logic [OUT_W-1:0] m_axis_tdata,     // result_node, found, is_empty,
                                                    // entry_total, misuse
    output int                    fail_count,
    output int                    pending_results
);

    localparam int RES_W = $bits(ldq_result_t);

    logic [LINK_W-1:0]     next_tbl [NODE_COUNT];
    logic [LINK_W-1:0]     prev_tbl [NODE_COUNT];
    logic [NODE_COUNT-1:0] member;
    logic [LINK_W-1:0]     head;
    logic [LINK_W-1:0]     tail;
    logic [COUNT_W-1:0]    count;
    ldq_result_t           expected_results [$];
    int                    words_checked;

    initial
    begin
        fail_count    = 0;
        words_checked = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("word %0d %s got %0d expected %0d",
                                      words_checked, name, got, want));
    endtask

    // take a linked node out of the chain; its own links stay as they were
    function automatic void detach_member(input logic [IDX_W-1:0] n);
        logic [LINK_W-1:0] nx;
        logic [LINK_W-1:0] pv;
        nx = next_tbl[n];
        pv = prev_tbl[n];
        if ({1'b0, n} == head)
        begin
            head = nx;
            if (head != NIL_CODE)
                prev_tbl[head[IDX_W-1:0]] = NIL_CODE;
            else
                tail = NIL_CODE;
        end
        else if ({1'b0, n} == tail)
        begin
            tail = pv;
            if (tail != NIL_CODE)
                next_tbl[tail[IDX_W-1:0]] = NIL_CODE;
            else
                head = NIL_CODE;
        end
        else
        begin
            if (pv != NIL_CODE)
                next_tbl[pv[IDX_W-1:0]] = nx;
            if (nx != NIL_CODE)
                prev_tbl[nx[IDX_W-1:0]] = pv;
        end
        member[n] = 1'b0;
        if (count != '0)
            count = count - COUNT_W'(1);
    endfunction

    function automatic ldq_result_t apply_command(input ldq_op_t op,
                                                  input logic [IDX_W-1:0] node);
        ldq_result_t       r;
        logic [LINK_W-1:0] end_node;
        r = '0;
        case (op)
            OP_PUSH_FRONT:
            begin
                if (member[node])
                    r.misuse = 1'b1;
                else
                begin
                    next_tbl[node] = head;
                    prev_tbl[node] = NIL_CODE;
                    if (head != NIL_CODE)
                        prev_tbl[head[IDX_W-1:0]] = {1'b0, node};
                    head = {1'b0, node};
                    if (tail == NIL_CODE)
                        tail = {1'b0, node};
                    member[node] = 1'b1;
                    count = count + COUNT_W'(1);
                end
            end
            OP_PUSH_BACK:
            begin
                if (member[node])
                    r.misuse = 1'b1;
                else
                begin
                    next_tbl[node] = NIL_CODE;
                    prev_tbl[node] = tail;
                    if (tail != NIL_CODE)
                        next_tbl[tail[IDX_W-1:0]] = {1'b0, node};
                    tail = {1'b0, node};
                    if (head == NIL_CODE)
                        head = {1'b0, node};
                    member[node] = 1'b1;
                    count = count + COUNT_W'(1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                end_node = (op == OP_POP_FRONT) ? head : tail;
                if (end_node != NIL_CODE)
                begin
                    r.result_node = end_node[IDX_W-1:0];
                    r.found       = 1'b1;
                    detach_member(end_node[IDX_W-1:0]);
                end
            end
            OP_PEEK_FRONT:
            begin
                if (head != NIL_CODE)
                begin
                    r.result_node = head[IDX_W-1:0];
                    r.found       = 1'b1;
                end
            end
            OP_PEEK_BACK:
            begin
                if (tail != NIL_CODE)
                begin
                    r.result_node = tail[IDX_W-1:0];
                    r.found       = 1'b1;
                end
            end
            OP_UNLINK:
            begin
                if (!member[node])
                    r.misuse = 1'b1;
                else
                    detach_member(node);
            end
            default:
            begin
                head   = NIL_CODE;
                tail   = NIL_CODE;
                count  = '0;
                member = '0;
            end
        endcase
        r.is_empty    = (head == NIL_CODE);
        r.entry_total = count;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ldq_result_t got;
        ldq_result_t want;
        if (!rst_n)
        begin
            expected_results.delete();
            member = '0;
            head   = NIL_CODE;
            tail   = NIL_CODE;
            count  = '0;
            pending_results <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = ldq_result_t'(m_axis_tdata[RES_W-1:0]);
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result word %0h with nothing expected",
                                              m_axis_tdata));
                else
                begin
                    want = expected_results.pop_front();
                    check_field("result_node", int'(got.result_node),
                                int'(want.result_node));
                    check_field("found", int'(got.found), int'(want.found));
                    check_field("is_empty", int'(got.is_empty), int'(want.is_empty));
                    check_field("entry_total", int'(got.entry_total),
                                int'(want.entry_total));
                    check_field("misuse", int'(got.misuse), int'(want.misuse));
                    check_field("pad", int'(m_axis_tdata[OUT_W-1:RES_W]), 0);
                end
                words_checked++;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(apply_command(ldq_op_t'(s_axis_tdata[2:0]),
                                                         s_axis_tdata[10:3]));
            pending_results <= expected_results.size();
        end
    end

endmodule
`default_nettype wire

// ----- tb/linked_deque_manager_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// linked_deque_manager_test
// Drives command words into the linked deque manager: a directed opening over
// empty, single-node, head, tail and middle cases and clear, then random
// phases that grow, balance, fill to the whole pool and drain the deque.
// The sender idles in bursts and the output side stalls on its own pattern;
// the checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module linked_deque_manager_test;
    import ldq_pkg::*;

    localparam int TOTAL_WORDS = 1730;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 20;

    typedef enum int {
        MIX_GROW,
        MIX_BALANCE,
        MIX_DRAIN
    } mix_t;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;     // operation, node_index
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;     // result_node, found, is_empty,
                                        // entry_total, misuse
    int               fail_count;
    int               pending_results;

    int               words_sent;
    int               burst_left;
    int               holds_asked;
    int               holds_served;
    logic [IDX_W-1:0] recent_nodes [$];

    linked_deque_manager dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    linked_deque_checker deque_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

    // output side: stretches of different stall styles, plus a long hold
    // whenever the sender asks for one
    initial
    begin : receiver
        int style;
        int stretch;
        int k;
        m_axis_tready <= 1'b0;
        holds_served = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            style   = $urandom_range(0, 3);
            stretch = $urandom_range(20, 120);
            for (k = 0; k < stretch; k++)
            begin
                @(posedge clk);
                if (holds_asked != holds_served)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    holds_served++;
                end
                case (style)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= (k % 4 != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_word(input ldq_op_t op, input logic [IDX_W-1:0] node);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - IDX_W - 3){1'b0}}, node, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        words_sent++;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
        begin
            recent_nodes.push_back(node);
            if (recent_nodes.size() > 48)
                void'(recent_nodes.pop_front());
        end
        else if (op == OP_CLEAR)
            recent_nodes.delete();
    endtask

    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic send_paced(input ldq_op_t op, input logic [IDX_W-1:0] node);
        send_word(op, node);
        pace_sender();
    endtask

    // no word goes out until every result word has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    function automatic ldq_op_t pick_op(input mix_t mode);
        int roll;
        roll = $urandom_range(0, 99);
        case (mode)
            MIX_GROW:
            begin
                if (roll < 28) return OP_PUSH_FRONT;
                if (roll < 56) return OP_PUSH_BACK;
                if (roll < 63) return OP_POP_FRONT;
                if (roll < 70) return OP_POP_BACK;
                if (roll < 75) return OP_PEEK_FRONT;
                if (roll < 80) return OP_PEEK_BACK;
                if (roll < 99) return OP_UNLINK;
            end
            MIX_BALANCE:
            begin
                if (roll < 20) return OP_PUSH_FRONT;
                if (roll < 40) return OP_PUSH_BACK;
                if (roll < 52) return OP_POP_FRONT;
                if (roll < 64) return OP_POP_BACK;
                if (roll < 70) return OP_PEEK_FRONT;
                if (roll < 76) return OP_PEEK_BACK;
                if (roll < 98) return OP_UNLINK;
            end
            default:
            begin
                if (roll < 12) return OP_PUSH_FRONT;
                if (roll < 24) return OP_PUSH_BACK;
                if (roll < 44) return OP_POP_FRONT;
                if (roll < 64) return OP_POP_BACK;
                if (roll < 70) return OP_PEEK_FRONT;
                if (roll < 76) return OP_PEEK_BACK;
                if (roll < 99) return OP_UNLINK;
            end
        endcase
        return OP_CLEAR;
    endfunction

    // unlinks mostly target nodes pushed lately, so most of them hit a member
    function automatic logic [IDX_W-1:0] pick_node(input ldq_op_t op);
        int pos;
        logic [IDX_W-1:0] node;
        if (op == OP_UNLINK && recent_nodes.size() > 0 && $urandom_range(0, 99) < 85)
        begin
            pos  = $urandom_range(0, recent_nodes.size() - 1);
            node = recent_nodes[pos];
            recent_nodes.delete(pos);
            return node;
        end
        return IDX_W'($urandom_range(0, NODE_COUNT - 1));
    endfunction

    task automatic run_mix(input mix_t mode, input int words, input bit with_hold);
        ldq_op_t op;
        if (with_hold)
            holds_asked++;
        for (int i = 0; i < words; i++)
        begin
            op = pick_op(mode);
            send_word(op, pick_node(op));
            // keep offering back to back while the output side holds off
            if (!(with_hold && i < 60))
                pace_sender();
        end
    endtask

    // every node of the pool linked once, in random order, then drained
    task automatic run_fill();
        logic [IDX_W-1:0] order [NODE_COUNT];
        logic [IDX_W-1:0] swap;
        int j;
        for (int i = 0; i < NODE_COUNT; i++)
            order[i] = IDX_W'(i);
        for (int i = NODE_COUNT - 1; i > 0; i--)
        begin
            j        = $urandom_range(i, 0);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        send_paced(OP_CLEAR, IDX_W'($urandom_range(0, NODE_COUNT - 1)));
        for (int i = 0; i < NODE_COUNT; i++)
            send_paced($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, order[i]);
        for (int i = 0; i < 6; i++)
            send_paced($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                       IDX_W'($urandom_range(0, NODE_COUNT - 1)));
        send_paced(OP_PEEK_FRONT, 8'h00);
        send_paced(OP_PEEK_BACK, 8'hff);
        run_mix(MIX_DRAIN, 300, 1'b0);
    endtask

    initial
    begin : stimulus
        int   phase;
        mix_t mode;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        words_sent  = 0;
        burst_left  = 1;
        holds_asked = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // empty deque: pops and peeks find nothing, unlink is misuse
        send_paced(OP_POP_FRONT, 8'h00);
        send_paced(OP_POP_BACK, 8'hff);
        send_paced(OP_PEEK_FRONT, 8'h55);
        send_paced(OP_PEEK_BACK, 8'haa);
        send_paced(OP_UNLINK, 8'h00);
        // build 170 0 255 85, then a push of a member
        send_paced(OP_PUSH_FRONT, 8'h00);
        send_paced(OP_PUSH_BACK, 8'hff);
        send_paced(OP_PUSH_FRONT, 8'haa);
        send_paced(OP_PUSH_BACK, 8'h55);
        send_paced(OP_PUSH_BACK, 8'h00);
        send_paced(OP_PEEK_FRONT, 8'h00);
        send_paced(OP_PEEK_BACK, 8'h00);
        // unlink middle, head, tail, then the last node
        send_paced(OP_UNLINK, 8'h00);
        send_paced(OP_UNLINK, 8'haa);
        send_paced(OP_UNLINK, 8'h55);
        send_paced(OP_UNLINK, 8'hff);
        send_paced(OP_PUSH_BACK, 8'h01);
        send_paced(OP_PUSH_BACK, 8'h02);
        send_paced(OP_PUSH_BACK, 8'h03);
        send_paced(OP_POP_BACK, 8'h00);
        send_paced(OP_POP_FRONT, 8'h00);
        send_paced(OP_POP_FRONT, 8'h00);
        // clear drops membership, so the same node is free again
        send_paced(OP_PUSH_FRONT, 8'h07);
        send_paced(OP_CLEAR, 8'h00);
        send_paced(OP_PEEK_FRONT, 8'h00);
        send_paced(OP_UNLINK, 8'h07);
        send_paced(OP_PUSH_FRONT, 8'h07);
        wait_drained();

        phase = 0;
        while (words_sent < TOTAL_WORDS)
        begin
            case (phase % 3)
                0:       mode = MIX_GROW;
                1:       mode = MIX_BALANCE;
                default: mode = MIX_DRAIN;
            endcase
            if (phase == 2)
                run_fill();
            else
                run_mix(mode, $urandom_range(120, 240), phase == 1);
            wait_drained();
            phase++;
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// ----- linked_deque_manager.f -----
rtl/core/ldq_pkg.sv
rtl/core/ldq_link_ram.sv
rtl/core/ldq_seq.sv
rtl/core/linked_deque_manager.sv
tb/linked_deque_checker.sv
tb/linked_deque_manager_test.sv
